[rtl/core/best_fit_region_allocator_top_assert.svh]
// Assertion macros for the best-fit region allocator.
// The using module provides signals named clk and rst.
`ifndef BEST_FIT_REGION_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_REGION_ALLOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked while out of reset.
`define BFRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define BFRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFRA_ASSERT(lbl, prop, msg)
`define BFRA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/core/bfra_pkg.sv]
package bfra_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Commands
  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_ALLOC    = 2'd1;
  localparam logic [1:0] CMD_CHECK    = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] region_base;
    logic [31:0] request_size;
    logic        first_of_check;
    logic        last_of_check;
  } bfra_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alloc_address;
    logic        check_fits;
    logic        check_done;
  } bfra_res_t;

  // Winner of a table scan
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rank;
    logic [31:0]      key;
    logic [31:0]      len;
    logic [31:0]      start;
    logic             tail_hit;
  } bfra_best_t;

endpackage

[rtl/core/bfra_ram.sv]
module bfra_ram #(
  parameter int W = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bfra_scan.sv]
module bfra_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      step,
  input  logic                      cand,
  input  logic [31:0]               key,
  input  logic [31:0]               len,
  input  logic [31:0]               start,
  input  logic [bfra_pkg::IDX_W-1:0] idx,
  input  logic [bfra_pkg::IDX_W-1:0] rank,
  input  logic                      tail_hit,
  output bfra_pkg::bfra_best_t      best
);
  import bfra_pkg::*;

  logic better;

  // Smallest key wins, earliest list position on ties
  assign better = cand && (!best.found || key < best.key ||
                           (key == best.key && rank < best.rank));

  // Winner register; only the found flag is reset
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best.found <= 1'b0;
    end else if (step && better) begin
      best.found <= 1'b1;
    end
    if (step && better) begin
      best.idx      <= idx;
      best.rank     <= rank;
      best.key      <= key;
      best.len      <= len;
      best.start    <= start;
      best.tail_hit <= tail_hit;
    end
  end

endmodule

[rtl/core/best_fit_region_allocator_top.sv]
// Best-fit region allocator.
// Request channel cmd_valid/cmd_ready/cmd_data carries add-free, allocate and
// fit-check commands; result channel res_valid/res_ready/res_data returns one
// result per request, in order.
// Each request scans the descriptor table out of a registered-read RAM, one
// entry per cycle, then writes back in the S_WRITE state. The first item of
// a fit check first copies the free lengths into the shadow RAM, one entry per
// cycle, before its scan. An unknown command, or a check item of an already
// failed sequence, goes from idle straight to the final state. One request is
// in flight at a time; the table scan sets the rate.
// Reset clears the valid bits, the check state and the result valid flag; the
// table starts empty, with no clearing pass. A stalled receiver holds the
// result in the output register; the next request may be accepted and worked
// on meanwhile, and waits in its final state until the register frees up.
`include "best_fit_region_allocator_top_assert.svh"

module best_fit_region_allocator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  bfra_pkg::bfra_cmd_t cmd_data,
  output logic                res_valid,
  input  logic                res_ready,
  output bfra_pkg::bfra_res_t res_data
);
  import bfra_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COPY  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  bfra_cmd_t        cmd_q;
  bfra_res_t        res_q;
  logic             accept;

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [TABLE_ENTRIES-1:0] shadow_valid;
  logic [IDX_W-1:0]         rank  [TABLE_ENTRIES];
  logic [IDX_W-1:0]         srank [TABLE_ENTRIES];
  logic                     check_failed;
  logic                     slot_found;
  logic [IDX_W-1:0]         slot_idx;

  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] raddr;

  logic [31:0] start_rdata, len_rdata, shadow_rdata;
  logic        main_we;
  logic [IDX_W-1:0] main_waddr;
  logic [31:0] start_wdata, len_wdata;
  logic        shadow_we;
  logic [IDX_W-1:0] shadow_waddr;
  logic [31:0] shadow_wdata;

  logic        is_add, is_alloc, is_check;
  logic        cur_v, tail, head, cand, step;
  logic [31:0] cur_len, key;
  logic [IDX_W-1:0] cur_rank;
  logic        exact;
  bfra_best_t  best;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign raddr     = cnt[IDX_W-1:0];

  assign is_add   = (cmd_q.command == CMD_ADD);
  assign is_alloc = (cmd_q.command == CMD_ALLOC);
  assign is_check = (cmd_q.command == CMD_CHECK);

  // Table and shadow memories
  bfra_ram #(.W(32), .DEPTH(TABLE_ENTRIES)) u_start_ram (
    .clk(clk), .we(main_we), .waddr(main_waddr), .wdata(start_wdata),
    .raddr(raddr), .rdata(start_rdata)
  );
  bfra_ram #(.W(32), .DEPTH(TABLE_ENTRIES)) u_len_ram (
    .clk(clk), .we(main_we), .waddr(main_waddr), .wdata(len_wdata),
    .raddr(raddr), .rdata(len_rdata)
  );
  bfra_ram #(.W(32), .DEPTH(TABLE_ENTRIES)) u_shadow_ram (
    .clk(clk), .we(shadow_we), .waddr(shadow_waddr), .wdata(shadow_wdata),
    .raddr(raddr), .rdata(shadow_rdata)
  );

  // Read pipeline: index of the entry whose data arrives this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN || state == S_COPY) &&
                (cnt < CNT_W'(TABLE_ENTRIES));
    end
    rd_idx <= raddr;
  end

  // Candidate for the scan
  always_comb begin
    cur_len  = is_check ? shadow_rdata : len_rdata;
    cur_v    = is_check ? shadow_valid[rd_idx] : entry_valid[rd_idx];
    cur_rank = is_check ? srank[rd_idx] : rank[rd_idx];
    tail     = (start_rdata + len_rdata) == cmd_q.region_base;
    head     = (cmd_q.region_base + cmd_q.request_size) == start_rdata;
    if (is_add) begin
      cand = cur_v && (tail || head);
      key  = 32'd0;
    end else begin
      cand = cur_v && (cur_len >= cmd_q.request_size);
      key  = cur_len;
    end
  end

  assign step = (state == S_SCAN) && rd_vld;

  bfra_scan u_scan (
    .clk(clk), .rst(rst), .clear(accept), .step(step), .cand(cand),
    .key(key), .len(cur_len), .start(start_rdata), .idx(rd_idx),
    .rank(cur_rank), .tail_hit(tail), .best(best)
  );

  assign exact = (best.len == cmd_q.request_size);

  // First free descriptor, found during the add scan
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      slot_found <= 1'b0;
    end else if (step && !entry_valid[rd_idx] && !slot_found) begin
      slot_found <= 1'b1;
    end
    if (step && !entry_valid[rd_idx] && !slot_found) begin
      slot_idx <= rd_idx;
    end
  end

  // Table write-back
  always_comb begin
    main_we     = 1'b0;
    main_waddr  = best.idx;
    start_wdata = cmd_q.region_base;
    len_wdata   = cmd_q.request_size;
    if (state == S_WRITE) begin
      if (is_add) begin
        if (best.found) begin
          main_we     = 1'b1;
          start_wdata = best.tail_hit ? best.start : cmd_q.region_base;
          len_wdata   = best.len + cmd_q.request_size;
        end else if (slot_found) begin
          main_we    = 1'b1;
          main_waddr = slot_idx;
        end
      end else if (is_alloc && best.found && !exact) begin
        main_we     = 1'b1;
        start_wdata = best.start + cmd_q.request_size;
        len_wdata   = best.len - cmd_q.request_size;
      end
    end
  end

  // Shadow writes: snapshot sweep, then check updates
  always_comb begin
    if (state == S_COPY) begin
      shadow_we    = rd_vld;
      shadow_waddr = rd_idx;
      shadow_wdata = len_rdata;
    end else begin
      shadow_we    = (state == S_WRITE) && is_check && best.found && !exact;
      shadow_waddr = best.idx;
      shadow_wdata = best.len - cmd_q.request_size;
    end
  end

  // Control and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      entry_valid  <= '0;
      shadow_valid <= '0;
      check_failed <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt <= '0;
            case (cmd_data.command)
              CMD_ADD, CMD_ALLOC: state <= S_SCAN;
              CMD_CHECK: begin
                if (cmd_data.first_of_check) begin
                  shadow_valid <= entry_valid;
                  check_failed <= 1'b0;
                  state        <= S_COPY;
                end else if (check_failed) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_COPY: begin
          if (cnt == CNT_W'(TABLE_ENTRIES)) begin
            cnt   <= '0;
            state <= S_SCAN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SCAN: begin
          if (cnt == CNT_W'(TABLE_ENTRIES)) begin
            state <= S_WRITE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_WRITE: begin
          if (is_add && !best.found && slot_found) begin
            entry_valid[slot_idx] <= 1'b1;
          end
          if (is_alloc && best.found && exact) begin
            entry_valid[best.idx] <= 1'b0;
          end
          if (is_check) begin
            check_failed <= !best.found;
            if (best.found && exact) begin
              shadow_valid[best.idx] <= 1'b0;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // List positions, kept per descriptor
  always_ff @(posedge clk) begin
    if (accept && cmd_data.command == CMD_CHECK && cmd_data.first_of_check) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        srank[i] <= rank[i];
      end
    end
    if (state == S_WRITE) begin
      if (is_add && !best.found && slot_found) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (entry_valid[i]) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
        rank[slot_idx] <= '0;
      end
      if (is_alloc && best.found && exact) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (entry_valid[i] && rank[i] > best.rank) begin
            rank[i] <= rank[i] - 1'b1;
          end
        end
      end
    end
  end

  // Request capture and result building
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_data;
      res_q <= '{status: ST_OK, alloc_address: 32'd0, check_fits: 1'b0,
                 check_done: (cmd_data.command == CMD_CHECK) && cmd_data.last_of_check};
    end
    if (state == S_WRITE) begin
      if (is_add) begin
        res_q.status <= (best.found || slot_found) ? ST_OK : ST_FULL;
      end else if (is_alloc) begin
        res_q.status        <= best.found ? ST_OK : ST_NOFIT;
        res_q.alloc_address <= best.found ? best.start : 32'd0;
      end else begin
        res_q.check_fits <= best.found;
      end
    end
    if (state == S_DONE && (!res_valid || res_ready)) begin
      res_data <= res_q;
    end
  end

  `BFRA_ASSERT(a_cnt_range, cnt <= CNT_W'(TABLE_ENTRIES), "scan counter out of range")
  `BFRA_ASSERT(a_res_from_done, $rose(res_valid) |-> $past(state == S_DONE),
               "result raised outside final state")
  `BFRA_ASSERT(a_fail_from_check,
               $rose(check_failed) |-> $past(state == S_WRITE) && $past(is_check),
               "check failure set outside check write-back")
  `BFRA_ASSERT(a_exact_frees,
               (state == S_WRITE && is_alloc && best.found && exact) |=>
               !entry_valid[$past(best.idx)],
               "exact fit did not free descriptor")
  `BFRA_ASSERT_ALWAYS(a_reset_idle, rst |=> state == S_IDLE && !res_valid,
                      "reset did not return to idle")

endmodule
